FILE: rtl/core/ptw_pkg.sv
package ptw_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned FlagW = 4;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIR_FAULT = 2'd1,
    ST_TBL_FAULT = 2'd2
  } status_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } opcode_t;

  // walk flag bits
  localparam int unsigned FL_SHADOW = 0;
  localparam int unsigned FL_SET_A  = 1;
  localparam int unsigned FL_SET_D  = 2;
  localparam int unsigned FL_USER   = 3;

  // entry bits
  localparam int unsigned E_P  = 0;
  localparam int unsigned E_W  = 1;
  localparam int unsigned E_U  = 2;
  localparam int unsigned E_A  = 5;
  localparam int unsigned E_D  = 6;
  localparam int unsigned E_PS = 7;

  typedef struct packed {
    opcode_t          opcode;
    logic [AddrW-1:0] virt_addr;
    logic [AddrW-1:0] dir_base;
    logic [FlagW-1:0] walk_flags;
    logic [AddrW-1:0] read_data;
  } walk_req_t;

  typedef struct packed {
    kind_t            kind;
    logic             last;
    logic [AddrW-1:0] mem_addr;
    logic [AddrW-1:0] write_data;
    logic [AddrW-1:0] phys_addr;
    status_t          status;
    logic [AddrW-1:0] dir_entry_addr;
    logic             dir_entry_valid;
    logic [AddrW-1:0] tbl_entry_addr;
    logic             tbl_entry_valid;
  } walk_rsp_t;

endpackage

FILE: rtl/core/two_level_page_table_walker.sv
// Latency: a beat's first result is presented on the cycle after it is accepted.
// Throughput: one request beat per cycle while each beat yields one result and rsp_stall is low;
//   a beat that yields more than one result (at most 3) holds the request side until its last
//   result is taken, set by the three-entry result buffer that drains one beat per cycle while rsp_stall is low.
// Reset (rst, synchronous): walk idle, held address/flag state zero, paging off,
//   result buffer empty.
module two_level_page_table_walker
  import ptw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      req_valid,
  output logic      req_stall,
  input  walk_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output walk_rsp_t rsp
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DIR  = 2'd1,
    PH_TBL  = 2'd2
  } phase_t;

  phase_t           phase, phase_next;
  logic             paging_on;
  logic [AddrW-1:0] held_vaddr, held_vaddr_next;
  logic [FlagW-1:0] held_flags, held_flags_next;
  logic [AddrW-1:0] held_dir_addr, held_dir_addr_next;
  logic [AddrW-1:0] held_tbl_addr, held_tbl_addr_next;

  walk_rsp_t        slots [3];
  walk_rsp_t        res [3];
  logic [1:0]       remain;
  logic [1:0]       res_cnt;
  logic             acc, pop;

  function automatic logic entry_fails(input logic [AddrW-1:0] e,
                                       input logic [FlagW-1:0] fl);
    entry_fails = !e[E_P] || (!e[E_W] && fl[FL_SET_D]) || (!e[E_U] && fl[FL_USER]);
  endfunction

  assign rsp_valid = (remain != 2'd0);
  assign rsp       = slots[0];
  assign pop       = rsp_valid && !rsp_stall;
  assign req_stall = (remain > 2'd1) || ((remain == 2'd1) && rsp_stall);
  assign acc       = req_valid && !req_stall;

  always_comb begin
    logic [AddrW-1:0] ent;
    logic [1:0]       n;
    walk_rsp_t        blank;

    blank              = '0;
    blank.kind         = KIND_READ;
    blank.status       = ST_OK;
    res[0]             = blank;
    res[1]             = blank;
    res[2]             = blank;
    n                  = 2'd0;
    ent                = req.read_data;
    phase_next         = PH_IDLE;
    held_vaddr_next    = held_vaddr;
    held_flags_next    = held_flags;
    held_dir_addr_next = held_dir_addr;
    held_tbl_addr_next = held_tbl_addr;

    if (req.opcode == OP_START) begin
      if (!paging_on && !req.walk_flags[FL_SHADOW]) begin
        res[n].kind      = KIND_DONE;
        res[n].phys_addr = req.virt_addr;
        n                = n + 2'd1;
      end else begin
        held_vaddr_next    = req.virt_addr;
        held_flags_next    = req.walk_flags;
        held_dir_addr_next = req.dir_base + {20'd0, req.virt_addr[31:22], 2'b00};
        held_tbl_addr_next = '0;
        phase_next         = PH_DIR;
        res[n].kind        = KIND_READ;
        res[n].mem_addr    = held_dir_addr_next;
        n                  = n + 2'd1;
      end
    end else begin
      case (phase)
        PH_DIR: begin
          if (entry_fails(ent, held_flags)) begin
            res[n].kind            = KIND_DONE;
            res[n].status          = ST_DIR_FAULT;
            res[n].dir_entry_addr  = held_dir_addr;
            res[n].dir_entry_valid = 1'b1;
            n                      = n + 2'd1;
          end else begin
            if (!held_flags[FL_SHADOW] && held_flags[FL_SET_A]) begin
              ent[E_A]          = 1'b1;
              res[n].kind       = KIND_WRITE;
              res[n].mem_addr   = held_dir_addr;
              res[n].write_data = ent;
              n                 = n + 2'd1;
            end
            if (ent[E_PS]) begin
              res[n].kind            = KIND_DONE;
              res[n].phys_addr       = {ent[31:22], 22'd0} + {10'd0, held_vaddr[21:0]};
              res[n].dir_entry_addr  = held_dir_addr;
              res[n].dir_entry_valid = 1'b1;
              n                      = n + 2'd1;
            end else begin
              held_tbl_addr_next = {ent[31:12], 12'd0} + {20'd0, held_vaddr[21:12], 2'b00};
              phase_next         = PH_TBL;
              res[n].kind        = KIND_READ;
              res[n].mem_addr    = held_tbl_addr_next;
              n                  = n + 2'd1;
            end
          end
        end
        PH_TBL: begin
          if (entry_fails(ent, held_flags)) begin
            res[n].kind            = KIND_DONE;
            res[n].status          = ST_TBL_FAULT;
            res[n].dir_entry_addr  = held_dir_addr;
            res[n].dir_entry_valid = 1'b1;
            res[n].tbl_entry_addr  = held_tbl_addr;
            res[n].tbl_entry_valid = 1'b1;
            n                      = n + 2'd1;
          end else begin
            if (!held_flags[FL_SHADOW] && held_flags[FL_SET_A]) begin
              ent[E_A]          = 1'b1;
              res[n].kind       = KIND_WRITE;
              res[n].mem_addr   = held_tbl_addr;
              res[n].write_data = ent;
              n                 = n + 2'd1;
            end
            if (!held_flags[FL_SHADOW] && held_flags[FL_SET_D]) begin
              ent[E_D]          = 1'b1;
              res[n].kind       = KIND_WRITE;
              res[n].mem_addr   = held_tbl_addr;
              res[n].write_data = ent;
              n                 = n + 2'd1;
            end
            res[n].kind            = KIND_DONE;
            res[n].phys_addr       = {ent[31:12], held_vaddr[11:0]};
            res[n].dir_entry_addr  = held_dir_addr;
            res[n].dir_entry_valid = 1'b1;
            res[n].tbl_entry_addr  = held_tbl_addr;
            res[n].tbl_entry_valid = 1'b1;
            n                      = n + 2'd1;
          end
        end
        default: begin
          // data with no walk pending: dropped
        end
      endcase
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
    res_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      paging_on     <= 1'b0;
      held_vaddr    <= '0;
      held_flags    <= '0;
      held_dir_addr <= '0;
      held_tbl_addr <= '0;
      remain        <= 2'd0;
    end else begin
      if (cfg_we) begin
        paging_on <= cfg_wdata;
      end
      if (acc) begin
        phase         <= phase_next;
        held_vaddr    <= held_vaddr_next;
        held_flags    <= held_flags_next;
        held_dir_addr <= held_dir_addr_next;
        held_tbl_addr <= held_tbl_addr_next;
        remain        <= res_cnt;
      end else if (pop) begin
        remain <= remain - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      slots[0] <= res[0];
      slots[1] <= res[1];
      slots[2] <= res[2];
    end else if (pop) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last |-> remain == 2'd1)
    else $error("last beat with more results queued");

  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
    remain == 2'd1 |-> rsp.last)
    else $error("final queued beat not marked last");

  a_write_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_WRITE |-> !rsp.last)
    else $error("write-back ended a beat sequence");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    remain == 2'd0 |-> !req_stall)
    else $error("request stalled with empty result buffer");

endmodule
